FILE: rtl/spq_pkg.sv
`default_nettype none

package spq_pkg;

    localparam int SPQ_CAPACITY      = 16;
    localparam int SPQ_PRIORITY_BITS = 8;
    localparam int SPQ_VALUE_BITS    = 32;

    typedef enum logic [1:0] {
        ST_PUSHED = 2'd0,
        ST_POPPED = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        RD_AT    = 2'd0,
        RD_BELOW = 2'd1,
        RD_ABOVE = 2'd2
    } t_rd_sel;

    typedef struct packed {
        logic    load_item;
        logic    idx_load_count;
        logic    idx_clear;
        logic    idx_inc;
        logic    idx_dec;
        t_rd_sel rd_sel;
        logic    wr_en;
        logic    wr_item;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    cap_front;
        logic    load_out;
        t_status out_status;
    } t_dp_cmd;

    typedef struct packed {
        logic is_pop;
        logic empty;
        logic full;
        logic idx_zero;
        logic stored_ge;
        logic more_pop;
    } t_dp_stat;

endpackage

`default_nettype wire

FILE: rtl/spq_ram.sv
`default_nettype none

module spq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/spq_ctrl.sv
`default_nettype none

module spq_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output      logic              o_in_stall,
    output      logic              o_out_valid,
    input  wire logic              i_out_stall,
    input  wire spq_pkg::t_dp_stat i_stat,
    output      spq_pkg::t_dp_cmd  o_cmd
);

    import spq_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_DECODE    = 9'b000000010,
        S_PUSH_RD   = 9'b000000100,
        S_PUSH_CHK  = 9'b000001000,
        S_POP_RD    = 9'b000010000,
        S_POP_CAP   = 9'b000100000,
        S_POP_MV_RD = 9'b001000000,
        S_POP_MV_WR = 9'b010000000,
        S_DONE      = 9'b100000000
    } t_state;

    t_state  r_state, n_state;
    t_status r_status, n_status;
    logic    r_out_valid, n_out_valid;
    logic    out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_status    = r_status;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        o_cmd.rd_sel     = RD_AT;
        o_cmd.out_status = r_status;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.is_pop) begin
                    if (i_stat.empty) begin
                        n_status = ST_EMPTY;
                        n_state  = S_DONE;
                    end else begin
                        o_cmd.idx_clear = 1'b1;
                        n_status = ST_POPPED;
                        n_state  = S_POP_RD;
                    end
                end else begin
                    if (i_stat.full) begin
                        n_status = ST_FULL;
                        n_state  = S_DONE;
                    end else begin
                        o_cmd.idx_load_count = 1'b1;
                        n_status = ST_PUSHED;
                        n_state  = S_PUSH_RD;
                    end
                end
            end
            S_PUSH_RD: begin
                if (i_stat.idx_zero) begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_item = 1'b1;
                    o_cmd.cnt_inc = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd_sel = RD_BELOW;
                    n_state = S_PUSH_CHK;
                end
            end
            S_PUSH_CHK: begin
                o_cmd.wr_en = 1'b1;
                if (i_stat.stored_ge) begin
                    o_cmd.wr_item = 1'b1;
                    o_cmd.cnt_inc = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_cmd.idx_dec = 1'b1;
                    n_state = S_PUSH_RD;
                end
            end
            S_POP_RD: begin
                o_cmd.rd_sel = RD_AT;
                n_state = S_POP_CAP;
            end
            S_POP_CAP: begin
                o_cmd.cap_front = 1'b1;
                n_state = S_POP_MV_RD;
            end
            S_POP_MV_RD: begin
                if (i_stat.more_pop) begin
                    o_cmd.rd_sel = RD_ABOVE;
                    n_state = S_POP_MV_WR;
                end else begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_POP_MV_WR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.idx_inc = 1'b1;
                n_state = S_POP_MV_RD;
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_status    <= ST_PUSHED;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_status    <= n_status;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

FILE: rtl/spq_dp.sv
`default_nettype none

module spq_dp #(
    parameter int CAPACITY      = spq_pkg::SPQ_CAPACITY,
    parameter int PRIORITY_BITS = spq_pkg::SPQ_PRIORITY_BITS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cmd,
    input  wire logic [spq_pkg::SPQ_VALUE_BITS-1:0] i_value,
    input  wire logic [PRIORITY_BITS-1:0]          i_priority_req,
    output      logic [1:0]                        o_status,
    output      logic [spq_pkg::SPQ_VALUE_BITS-1:0] o_out_value,
    output      logic [PRIORITY_BITS-1:0]          o_out_priority,
    output      logic [$clog2(CAPACITY+1)-1:0]     o_occupancy,
    input  wire spq_pkg::t_dp_cmd                  i_dp_cmd,
    output      spq_pkg::t_dp_stat                 o_stat
);

    import spq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int VW = SPQ_VALUE_BITS;
    localparam int DW = PRIORITY_BITS + VW;

    logic                     r_is_pop;
    logic [VW-1:0]            r_value;
    logic [PRIORITY_BITS-1:0] r_pri;
    logic [AW-1:0]            r_idx;
    logic [CW-1:0]            r_count;
    logic [VW-1:0]            r_front_val;
    logic [PRIORITY_BITS-1:0] r_front_pri;
    logic [1:0]               r_status;
    logic [VW-1:0]            r_out_value;
    logic [PRIORITY_BITS-1:0] r_out_pri;
    logic [CW-1:0]            r_occ;

    logic [AW-1:0]            rd_addr;
    logic [DW-1:0]            rd_data;
    logic [DW-1:0]            wr_data;
    logic [PRIORITY_BITS-1:0] rd_pri;
    logic [VW-1:0]            rd_val;
    logic [CW:0]              idx_next_wide;

    assign rd_pri = rd_data[DW-1 -: PRIORITY_BITS];
    assign rd_val = rd_data[VW-1:0];

    always_comb begin
        case (i_dp_cmd.rd_sel)
            RD_AT:    rd_addr = r_idx;
            RD_BELOW: rd_addr = r_idx - AW'(1);
            RD_ABOVE: rd_addr = r_idx + AW'(1);
            default:  rd_addr = r_idx;
        endcase
    end

    assign wr_data = i_dp_cmd.wr_item ? {r_pri, r_value} : rd_data;

    spq_ram #(
        .WIDTH (DW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_dp_cmd.wr_en),
        .i_waddr (r_idx),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    assign idx_next_wide = (CW+1)'(r_idx) + (CW+1)'(1);

    assign o_stat.is_pop    = r_is_pop;
    assign o_stat.empty     = (r_count == '0);
    assign o_stat.full      = (r_count == CW'(CAPACITY));
    assign o_stat.idx_zero  = (r_idx == '0);
    assign o_stat.stored_ge = (rd_pri >= r_pri);
    assign o_stat.more_pop  = (idx_next_wide < {1'b0, r_count});

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load_item) begin
            r_is_pop <= i_cmd;
            r_value  <= i_value;
            r_pri    <= i_priority_req;
        end
        if (i_dp_cmd.idx_load_count) begin
            r_idx <= AW'(r_count);
        end else if (i_dp_cmd.idx_clear) begin
            r_idx <= '0;
        end else if (i_dp_cmd.idx_inc) begin
            r_idx <= r_idx + AW'(1);
        end else if (i_dp_cmd.idx_dec) begin
            r_idx <= r_idx - AW'(1);
        end
        if (i_dp_cmd.cap_front) begin
            r_front_val <= rd_val;
            r_front_pri <= rd_pri;
        end
        if (i_dp_cmd.load_out) begin
            r_status <= i_dp_cmd.out_status;
            r_occ    <= r_count;
            if (i_dp_cmd.out_status == ST_POPPED) begin
                r_out_value <= r_front_val;
                r_out_pri   <= r_front_pri;
            end else begin
                r_out_value <= '0;
                r_out_pri   <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_dp_cmd.cnt_inc) begin
            r_count <= r_count + CW'(1);
        end else if (i_dp_cmd.cnt_dec) begin
            r_count <= r_count - CW'(1);
        end
    end

    assign o_status       = r_status;
    assign o_out_value    = r_out_value;
    assign o_out_priority = r_out_pri;
    assign o_occupancy    = r_occ;

endmodule

`default_nettype wire

FILE: rtl/stable_priority_queue.sv
// A push moves each lower-priority entry back one slot from the tail and writes the new
// entry behind the last one of equal or higher priority; a pop captures the front entry
// and moves every other entry forward; a rejected push or an empty pop skips both.
// One operation is in flight at a time: the next beat is accepted in the cycle after the
// result is loaded, and a result stalled at the output delays the loading of the next.
// Reset empties the queue and clears any pending result; the entry memory is not cleared.
`default_nettype none

module stable_priority_queue #(
    parameter int CAPACITY      = spq_pkg::SPQ_CAPACITY,
    parameter int PRIORITY_BITS = spq_pkg::SPQ_PRIORITY_BITS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output      logic                              o_in_stall,
    input  wire logic                              i_cmd,
    input  wire logic [spq_pkg::SPQ_VALUE_BITS-1:0] i_value,
    input  wire logic [PRIORITY_BITS-1:0]          i_priority_req,
    output      logic                              o_out_valid,
    input  wire logic                              i_out_stall,
    output      logic [1:0]                        o_status,
    output      logic [spq_pkg::SPQ_VALUE_BITS-1:0] o_out_value,
    output      logic [PRIORITY_BITS-1:0]          o_out_priority,
    output      logic [$clog2(CAPACITY+1)-1:0]     o_occupancy
);

    import spq_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    spq_dp #(
        .CAPACITY      (CAPACITY),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (i_cmd),
        .i_value        (i_value),
        .i_priority_req (i_priority_req),
        .o_status       (o_status),
        .o_out_value    (o_out_value),
        .o_out_priority (o_out_priority),
        .o_occupancy    (o_occupancy),
        .i_dp_cmd       (dp_cmd),
        .o_stat         (dp_stat)
    );

endmodule

`default_nettype wire

FILE: sim/stable_priority_queue_tb.sv
`timescale 1ns / 1ps

module stable_priority_queue_tb;

    import spq_pkg::*;

    localparam int CAPACITY      = SPQ_CAPACITY;
    localparam int PRIORITY_BITS = SPQ_PRIORITY_BITS;
    localparam int VALUE_BITS    = SPQ_VALUE_BITS;
    localparam int OCC_BITS      = $clog2(CAPACITY + 1);
    localparam int HOLD_CYCLES   = 200;
    localparam int DRAIN_CYCLES  = 48;
    localparam int PHASE_ITEMS   = 482;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    typedef struct {
        logic                     cmd;
        logic [VALUE_BITS-1:0]    value;
        logic [PRIORITY_BITS-1:0] prio;
    } command_t;

    typedef struct {
        t_status                  status;
        logic [VALUE_BITS-1:0]    value;
        logic [PRIORITY_BITS-1:0] prio;
        logic [OCC_BITS-1:0]      occupancy;
    } reply_t;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic                     i_cmd = CMD_PUSH;
    logic [VALUE_BITS-1:0]    i_value = '0;
    logic [PRIORITY_BITS-1:0] i_priority_req = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic [1:0]               o_status;
    logic [VALUE_BITS-1:0]    o_out_value;
    logic [PRIORITY_BITS-1:0] o_out_priority;
    logic [OCC_BITS-1:0]      o_occupancy;

    command_t                 command_backlog[$];
    reply_t                   expected_replies[$];
    logic [VALUE_BITS-1:0]    shadow_values[$];
    logic [PRIORITY_BITS-1:0] shadow_prios[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit send_pause = 1'b0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int fail_count = 0;

    stable_priority_queue #(
        .CAPACITY      (CAPACITY),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cmd          (i_cmd),
        .i_value        (i_value),
        .i_priority_req (i_priority_req),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_out_value    (o_out_value),
        .o_out_priority (o_out_priority),
        .o_occupancy    (o_occupancy)
    );

    always #5 i_clk = ~i_clk;

    // Equal priorities go behind every stored entry of the same priority.
    task automatic predict_command(input command_t c);
        reply_t r;
        int     pos;
        r.status = ST_PUSHED;
        r.value  = '0;
        r.prio   = '0;
        if (c.cmd == CMD_PUSH) begin
            if (shadow_values.size() >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                pos = 0;
                while (pos < shadow_values.size() && shadow_prios[pos] >= c.prio) begin
                    pos++;
                end
                shadow_values.insert(pos, c.value);
                shadow_prios.insert(pos, c.prio);
            end
        end else if (shadow_values.size() == 0) begin
            r.status = ST_EMPTY;
        end else begin
            r.status = ST_POPPED;
            r.value  = shadow_values.pop_front();
            r.prio   = shadow_prios.pop_front();
        end
        r.occupancy = OCC_BITS'(shadow_values.size());
        expected_replies.push_back(r);
    endtask

    task automatic add_command(input logic cmd, input logic [VALUE_BITS-1:0] value,
                               input logic [PRIORITY_BITS-1:0] prio);
        command_t c;
        c.cmd   = cmd;
        c.value = value;
        c.prio  = prio;
        command_backlog.push_back(c);
    endtask

    // Bursts alternate between mostly pushes and mostly pops so the queue swings
    // between full and empty; a narrow priority band makes ties common.
    task automatic add_random_commands(input int count);
        int                       push_pct;
        int                       pick;
        logic [VALUE_BITS-1:0]    value;
        logic [PRIORITY_BITS-1:0] prio;
        push_pct = 50;
        for (int n = 0; n < count; n++) begin
            if (n % 24 == 0) begin
                push_pct = ((n / 24) % 2 == 0) ? $urandom_range(90, 60) : $urandom_range(45, 10);
            end
            pick = $urandom_range(15);
            case (pick)
                0:       value = 32'h8000_0000;
                1:       value = 32'h7fff_ffff;
                2:       value = 32'h0000_0000;
                3:       value = 32'hffff_ffff;
                default: value = $urandom;
            endcase
            pick = $urandom_range(11);
            if (pick < 4) begin
                prio = PRIORITY_BITS'($urandom_range(3));
            end else if (pick == 4) begin
                prio = '0;
            end else if (pick == 5) begin
                prio = '1;
            end else begin
                prio = PRIORITY_BITS'($urandom);
            end
            add_command(($urandom_range(99) < push_pct) ? CMD_PUSH : CMD_POP, value, prio);
        end
    endtask

    task automatic wait_drained();
        while (command_backlog.size() != 0 || i_in_valid || expected_replies.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct,
                             input bit do_hold, input bit do_pause);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        add_random_commands(PHASE_ITEMS);
        while (command_backlog.size() > PHASE_ITEMS / 2) begin
            @(negedge i_clk);
        end
        if (do_hold) begin
            hold_requests++;
        end
        if (do_pause) begin
            send_pause = 1'b1;
            while (i_in_valid || expected_replies.size() != 0) begin
                @(negedge i_clk);
            end
            send_pause = 1'b0;
        end
        wait_drained();
    endtask

    always @(posedge i_clk) begin : drive_commands
        command_t c;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                c.cmd   = i_cmd;
                c.value = i_value;
                c.prio  = i_priority_req;
                predict_command(c);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (!send_pause && command_backlog.size() != 0
                        && $urandom_range(99) >= send_idle_pct) begin
                    c = command_backlog.pop_front();
                    i_in_valid     <= 1'b1;
                    i_cmd          <= c.cmd;
                    i_value        <= c.value;
                    i_priority_req <= c.prio;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : drive_out_stall
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_served + 1;
            hold_left   <= HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin : check_replies
        reply_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_replies.size() == 0) begin
                $error("unexpected result beat: status %0d", o_status);
                fail_count++;
            end else begin
                want = expected_replies.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    fail_count++;
                end
                if (o_out_value !== want.value) begin
                    $error("out_value: expected %0d, got %0d",
                           $signed(want.value), $signed(o_out_value));
                    fail_count++;
                end
                if (o_out_priority !== want.prio) begin
                    $error("out_priority: expected %0d, got %0d", want.prio, o_out_priority);
                    fail_count++;
                end
                if (o_occupancy !== want.occupancy) begin
                    $error("occupancy: expected %0d, got %0d", want.occupancy, o_occupancy);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        add_command(CMD_POP,  32'hffff_ffff, 8'hff);
        add_command(CMD_PUSH, 32'h7fff_ffff, 8'd255);
        add_command(CMD_PUSH, 32'h8000_0000, 8'd0);
        add_command(CMD_PUSH, 32'd1,         8'd128);
        add_command(CMD_PUSH, 32'd2,         8'd128);
        add_command(CMD_PUSH, 32'd3,         8'd128);
        add_command(CMD_PUSH, 32'hffff_ffff, 8'd0);
        add_command(CMD_PUSH, 32'd0,         8'd255);
        add_command(CMD_PUSH, 32'd4,         8'd129);
        add_command(CMD_PUSH, 32'd5,         8'd127);
        add_command(CMD_PUSH, 32'd6,         8'd128);
        add_command(CMD_PUSH, 32'd7,         8'd1);
        add_command(CMD_PUSH, 32'd8,         8'd254);
        add_command(CMD_PUSH, 32'd9,         8'd128);
        add_command(CMD_PUSH, 32'd10,        8'd0);
        add_command(CMD_PUSH, 32'd11,        8'd255);
        add_command(CMD_PUSH, 32'd12,        8'd64);
        add_command(CMD_PUSH, 32'd13,        8'd200);
        for (int n = 0; n < 6; n++) begin
            add_command(CMD_POP, 32'h5555_aaaa, 8'haa);
        end
        wait_drained();

        run_phase(0, 0, 1'b1, 1'b0);
        run_phase(49, 0, 1'b0, 1'b0);
        run_phase(0, 49, 1'b0, 1'b1);
        run_phase(17, 17, 1'b0, 1'b0);

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && expected_replies.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
